// ----- src/point_hyperplane_distance_core_assert.svh -----
// Assertion macros shared by the distance core modules.
`ifndef POINT_HYPERPLANE_DISTANCE_CORE_ASSERT_SVH
`define POINT_HYPERPLANE_DISTANCE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PHD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phd assertion failed");

// Next-cycle implication, disabled while in reset.
`define PHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phd assertion failed");

`endif

// ----- src/phd_pkg.sv -----
package phd_pkg;

    localparam int ACC_W   = 42;             // dot and norm accumulators
    localparam int TOTAL_W = ACC_W + 1;      // dot plus aligned offset
    localparam int DVD_W   = TOTAL_W + 4;    // magnitude scaled by 16
    localparam int ROOT_W  = ACC_W / 2;      // floor root of the norm
    localparam int DIST_W  = 32;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic signed [15:0] point_value;
        logic signed [15:0] plane_value;
        logic signed [15:0] plane_offset;
        logic               last_element;
    } t_in_word;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              zero_plane;
    } t_out_word;

    // One finished vector handed from the accumulators to the back end.
    typedef struct packed {
        logic signed [TOTAL_W-1:0] total;
        logic [ACC_W-1:0]          norm;
    } t_job;

endpackage

// ----- src/phd_front.sv -----
module phd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  phd_pkg::t_in_word i_word,
    output logic              o_stall,
    input  logic              i_queue_full,
    output logic              o_push,
    output phd_pkg::t_job     o_job
);

    logic [phd_pkg::ACC_W-1:0]          r_dot;
    logic [phd_pkg::ACC_W-1:0]          r_norm;
    logic [phd_pkg::ACC_W-1:0]          n_dot;
    logic [phd_pkg::ACC_W-1:0]          n_norm;
    logic signed [31:0]                 w_dot_prod;
    logic signed [31:0]                 w_norm_prod;
    logic signed [phd_pkg::TOTAL_W-1:0] w_offset;
    logic                               w_accept;

    assign o_stall  = i_queue_full;
    assign w_accept = i_valid && !o_stall;

    assign w_dot_prod  = i_word.point_value * i_word.plane_value;
    assign w_norm_prod = i_word.plane_value * i_word.plane_value;

    // Accumulators wrap modulo 2^42.
    assign n_dot  = r_dot + {{(phd_pkg::ACC_W-32){w_dot_prod[31]}}, w_dot_prod};
    assign n_norm = r_norm + {{(phd_pkg::ACC_W-32){1'b0}}, w_norm_prod};

    // Offset moves to the product scale: Q.12 -> Q.24.
    assign w_offset = {{(phd_pkg::TOTAL_W-28){i_word.plane_offset[15]}},
                       i_word.plane_offset, 12'b0};

    assign o_push      = w_accept && i_word.last_element;
    assign o_job.total = $signed({n_dot[phd_pkg::ACC_W-1], n_dot}) + w_offset;
    assign o_job.norm  = n_norm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot  <= '0;
            r_norm <= '0;
        end else if (w_accept) begin
            if (i_word.last_element) begin
                r_dot  <= '0;
                r_norm <= '0;
            end else begin
                r_dot  <= n_dot;
                r_norm <= n_norm;
            end
        end
    end

endmodule

// ----- src/phd_queue.sv -----
module phd_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  phd_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output phd_pkg::t_job o_job
);

`include "point_hyperplane_distance_core_assert.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    phd_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] ptr);
        f_next = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `PHD_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `PHD_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid)
    `PHD_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))

endmodule

// ----- src/phd_back.sv -----
module phd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  phd_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    output phd_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);

`include "point_hyperplane_distance_core_assert.svh"

    localparam int ACC_W   = phd_pkg::ACC_W;
    localparam int TOTAL_W = phd_pkg::TOTAL_W;
    localparam int DVD_W   = phd_pkg::DVD_W;
    localparam int ROOT_W  = phd_pkg::ROOT_W;
    localparam int DIST_W  = phd_pkg::DIST_W;
    localparam int CNT_W   = $clog2(DVD_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQRT,
        S_DIV,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [ACC_W-1:0]   r_rad;      // radicand remainder
    logic [ACC_W:0]     r_root;
    logic [ACC_W-1:0]   r_bit;
    logic [CNT_W-1:0]   r_cnt;
    logic [DVD_W-1:0]   r_dvd;
    logic [DVD_W-1:0]   r_quo;
    logic [ROOT_W-1:0]  r_rem;
    logic               r_zero;
    logic               r_out_valid;
    phd_pkg::t_out_word r_out_word;

    logic [TOTAL_W-1:0] w_mag;
    logic [ACC_W:0]     w_trial;
    logic               w_take;
    logic [ROOT_W-1:0]  w_divisor;
    logic [ROOT_W:0]    w_shift;
    logic [ROOT_W:0]    w_diff;
    logic               w_qbit;
    logic               w_out_free;
    logic [DIST_W-1:0]  w_dist;

    assign o_pop       = (r_state == S_IDLE) && i_job_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_mag = i_job.total[TOTAL_W-1] ? TOTAL_W'(-i_job.total) : TOTAL_W'(i_job.total);

    // Square root, one result bit per cycle.
    assign w_trial = r_root + {1'b0, r_bit};
    assign w_take  = ({1'b0, r_rad} >= w_trial);

    // Restoring divide, one quotient bit per cycle.
    assign w_divisor = r_root[ROOT_W-1:0];
    assign w_shift   = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff    = w_shift - {1'b0, w_divisor};
    assign w_qbit    = (w_shift >= {1'b0, w_divisor});

    assign w_dist = (r_quo[DVD_W-1:DIST_W] != '0) ? phd_pkg::DIST_MAX : r_quo[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // load a finished word, or drop the one just taken
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid           <= 1'b1;
                r_out_word.distance   <= r_zero ? phd_pkg::DIST_MAX : w_dist;
                r_out_word.zero_plane <= r_zero;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_rad  <= i_job.norm;
                        r_root <= '0;
                        r_bit  <= ACC_W'(1) << (ACC_W - 2);
                        r_cnt  <= CNT_W'(ROOT_W - 1);
                        r_dvd  <= {w_mag, 4'b0};
                        r_zero <= (i_job.norm == '0);
                        // zero plane skips the arithmetic
                        r_state <= (i_job.norm == '0) ? S_DONE : S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_take) begin
                        r_rad  <= r_rad - w_trial[ACC_W-1:0];
                        r_root <= (r_root >> 1) + {1'b0, r_bit};
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(DVD_W - 1);
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DIV: begin
                    r_rem <= w_qbit ? w_diff[ROOT_W-1:0] : w_shift[ROOT_W-1:0];
                    r_quo <= {r_quo[DVD_W-2:0], w_qbit};
                    r_dvd <= r_dvd << 1;
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `PHD_ASSERT_IMPL(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV,
        (w_divisor != '0) && (r_root[ACC_W:ROOT_W] == '0))
    `PHD_ASSERT_NEXT(a_zero_plane, i_clk, i_rst_n, o_pop && (i_job.norm == '0),
        (r_state == S_DONE) && r_zero)

endmodule

// ----- src/point_hyperplane_distance_core.sv -----
// Streaming point-to-hyperplane distance. The front end accepts one element
// (point coordinate, plane coefficient) per cycle and accumulates the dot
// product and squared norm; the element flagged last closes the vector and
// queues it, so the next vector can start streaming in the following cycle.
// The back end then loads the job, takes a bit-serial square root of the norm
// (ROOT_W = 21 result bits), divides the scaled magnitude by the root bit
// by bit and registers the result; a zero plane skips both. Up to QUEUE_DEPTH
// closed vectors wait between the two; once the queue is full, the input
// stalls until the back end takes the oldest. The result sits in an output
// register, so the back end starts the next vector while it waits to be taken.
module point_hyperplane_distance_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  phd_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output phd_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);

    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_job_valid;
    phd_pkg::t_job w_push_job;
    phd_pkg::t_job w_pop_job;

    phd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_word       (i_in_word),
        .o_stall      (o_in_stall),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    phd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_job   (w_pop_job)
    );

    phd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_pop_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule
